/* hdl/walk_count_matrix_power_core_macros.svh */
// assertion macros for the walk count matrix power core
// clocked on clk_i, disabled while rst_ni is low; empty under synthesis
`ifndef WALK_COUNT_MATRIX_POWER_CORE_MACROS_SVH
`define WALK_COUNT_MATRIX_POWER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WCMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WCMP_ASSERT(lbl, prop, msg)
`define WCMP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/wcmp_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types of the walk count matrix power core
// no dependencies
package wcmp_pkg;

  localparam int VERTICES_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;
  localparam int ADJ_W          = 64;
  localparam int ADJ_STRIDE     = 8;
  localparam int LEN_W          = 16;
  localparam int VTX_W          = 3;
  localparam int CNT_W          = 32;

  // commands from the sequencer to every cell of the ring
  typedef struct packed {
    logic             init;
    logic             load_y;
    logic             step;
    logic             first;
    logic             sel_b;
    logic             commit_p;
    logic             commit_b;
    logic [VTX_W-1:0] col;
    logic [VTX_W-1:0] shift;
  } cell_ctrl_t;

endpackage

/* hdl/wcmp_in_if.sv */
`timescale 1ns / 1ps
// input channel of the walk count matrix power core
// depends on wcmp_pkg
interface wcmp_in_if;
  logic                        valid;
  logic                        ready;
  logic [wcmp_pkg::LEN_W-1:0]  walk_length;
  modport source (output valid, output walk_length, input ready);
  modport sink   (input valid, input walk_length, output ready);
endinterface

/* hdl/wcmp_out_if.sv */
`timescale 1ns / 1ps
// result channel of the walk count matrix power core
// depends on wcmp_pkg
interface wcmp_out_if;
  logic                        valid;
  logic                        ready;
  logic [wcmp_pkg::VTX_W-1:0]  from_vertex;
  logic [wcmp_pkg::VTX_W-1:0]  to_vertex;
  logic [wcmp_pkg::CNT_W-1:0]  walk_count;
  logic                        last_entry;
  modport source (output valid, output from_vertex, output to_vertex,
                  output walk_count, output last_entry, input ready);
  modport sink   (input valid, input from_vertex, input to_vertex,
                  input walk_count, input last_entry, output ready);
endinterface

/* hdl/wcmp_cfg_if.sv */
`timescale 1ns / 1ps
// configuration write channel of the walk count matrix power core
// depends on wcmp_pkg
interface wcmp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wcmp_pkg::ADJ_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/walk_count_matrix_power_core.sv */
`timescale 1ns / 1ps
// walk count by adjacency matrix power: ring of VERTICES cells, one multiplier per cell
// each bit of the 16-bit exponent, up to its highest set bit, costs a decide step plus one
// or two matrix products; then VERTICES^2 result beats follow; one item at a time
// rst_ni low clears control state and the adjacency register; matrix rows are not reset
// depends on wcmp_pkg, wcmp_in_if, wcmp_out_if, wcmp_cfg_if, wcmp_cell and the macro header
`include "walk_count_matrix_power_core_macros.svh"
module walk_count_matrix_power_core #(
  parameter int VERTICES   = wcmp_pkg::VERTICES_DEF,
  parameter int COUNT_BITS = wcmp_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wcmp_in_if.sink     in_ch,
  wcmp_out_if.source  out_ch,
  wcmp_cfg_if.sink    cfg_ch
);
  localparam int N  = VERTICES;
  localparam int CW = (COUNT_BITS > 32) ? 32 : COUNT_BITS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INIT   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic                            commit_q, commit_d;
  logic [wcmp_pkg::LEN_W-1:0]      e_q, e_d;
  logic                            sq_q, sq_d;
  logic [IW-1:0]                   c_q, c_d, s_q, s_d;
  logic [IW-1:0]                   ei_q, ei_d, ej_q, ej_d;
  logic [wcmp_pkg::ADJ_W-1:0]      adj_q;
  logic                            ov_q;
  logic [wcmp_pkg::VTX_W-1:0]      from_q, to_q;
  logic [wcmp_pkg::CNT_W-1:0]      cnt_q;
  logic                            last_q;
  logic                            load_out;
  logic                            last_ent;
  logic                            in_beat;
  logic                            last_corner;
  wcmp_pkg::cell_ctrl_t            ctrl;
  logic [CW-1:0]                   ylink   [N];
  logic [CW-1:0]                   rd_data [N];

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= '0;
    end else if (cfg_ch.valid) begin
      adj_q <= cfg_ch.data;
    end
  end

  assign in_ch.ready = (state_q == ST_IDLE) && !commit_q;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign last_ent    = (ei_q == IW'(N - 1)) && (ej_q == IW'(N - 1));
  assign load_out    = (state_q == ST_EMIT) && (!ov_q || out_ch.ready);

  // sequencer
  always_comb begin
    state_d  = state_q;
    commit_d = 1'b0;
    e_d      = e_q;
    sq_d     = sq_q;
    c_d      = c_q;
    s_d      = s_q;
    ei_d     = ei_q;
    ej_d     = ej_q;
    ctrl     = '0;
    ctrl.col   = wcmp_pkg::VTX_W'(c_q);
    ctrl.shift = wcmp_pkg::VTX_W'(s_q);
    ctrl.sel_b = sq_q;
    ctrl.first = (s_q == '0);
    unique case (state_q)
      ST_IDLE: begin
        if (commit_q) begin
          // finish the product that the previous drain closed
          ctrl.commit_p = !sq_q;
          ctrl.commit_b = sq_q;
          if (!sq_q) begin
            sq_d        = 1'b1;
            ctrl.load_y = 1'b1;
            c_d         = '0;
            s_d         = '0;
            state_d     = ST_MUL;
          end else begin
            e_d     = e_q >> 1;
            state_d = ST_DECIDE;
          end
        end else if (in_ch.valid) begin
          e_d     = in_ch.walk_length;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        ctrl.init = 1'b1;
        state_d   = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (e_q == '0) begin
          ei_d    = '0;
          ej_d    = '0;
          state_d = ST_EMIT;
        end else begin
          ctrl.load_y = 1'b1;
          sq_d        = !e_q[0];
          c_d         = '0;
          s_d         = '0;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.step = 1'b1;
        if (c_q == IW'(N - 1)) begin
          c_d = '0;
          if (s_q == IW'(N - 1)) begin
            state_d = ST_DRAIN;
          end else begin
            s_d = s_q + 1'b1;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        commit_d = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_EMIT: begin
        if (load_out) begin
          if (last_ent) begin
            state_d = ST_IDLE;
          end else if (ej_q == IW'(N - 1)) begin
            ej_d = '0;
            ei_d = ei_q + 1'b1;
          end else begin
            ej_d = ej_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      commit_q <= 1'b0;
      e_q      <= '0;
      sq_q     <= 1'b0;
      c_q      <= '0;
      s_q      <= '0;
      ei_q     <= '0;
      ej_q     <= '0;
    end else begin
      state_q  <= state_d;
      commit_q <= commit_d;
      e_q      <= e_d;
      sq_q     <= sq_d;
      c_q      <= c_d;
      s_q      <= s_d;
      ei_q     <= ei_d;
      ej_q     <= ej_d;
    end
  end

  // ring of cells, base rows pass to the lower neighbor
  for (genvar j = 0; j < N; j++) begin : g_cell
    wcmp_cell #(.N(N), .CW(CW), .J(j)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .adj_row_i (adj_q[j*wcmp_pkg::ADJ_STRIDE +: wcmp_pkg::ADJ_STRIDE]),
      .y_i       (ylink[(j + 1) % N]),
      .y_o       (ylink[j]),
      .rd_idx_i  (ej_q),
      .rd_data_o (rd_data[j])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (load_out) begin
      ov_q <= 1'b1;
    end else if (out_ch.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      from_q <= wcmp_pkg::VTX_W'(ei_q);
      to_q   <= wcmp_pkg::VTX_W'(ej_q);
      cnt_q  <= wcmp_pkg::CNT_W'(rd_data[ei_q]);
      last_q <= last_ent;
    end
  end

  assign out_ch.valid       = ov_q;
  assign out_ch.from_vertex = from_q;
  assign out_ch.to_vertex   = to_q;
  assign out_ch.walk_count  = cnt_q;
  assign out_ch.last_entry  = last_q;

  // checks
  assign last_corner = (from_q == wcmp_pkg::VTX_W'(N - 1)) && (to_q == wcmp_pkg::VTX_W'(N - 1));
  `WCMP_ASSERT(a_last_corner, !(ov_q && last_q) || last_corner, "last beat off the final entry")
  `WCMP_ASSERT_NEXT(a_accept_init, in_beat, state_q == ST_INIT, "no init after accepted beat")
  `WCMP_ASSERT_NEXT(a_exp_shift, commit_q && sq_q, e_q == ($past(e_q) >> 1), "exponent not halved")
  `WCMP_ASSERT(a_no_emit_in_mul, !(load_out && (state_q == ST_MUL)), "result loaded mid product")

endmodule

/* hdl/wcmp_cell.sv */
`timescale 1ns / 1ps
// one ring cell: holds row J of the power and base matrices and one rotating base row
// depends on wcmp_pkg
module wcmp_cell #(
  parameter int N  = wcmp_pkg::VERTICES_DEF,
  parameter int CW = wcmp_pkg::CNT_W,
  parameter int J  = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wcmp_pkg::cell_ctrl_t             ctrl_i,
  input  logic [wcmp_pkg::ADJ_STRIDE-1:0]  adj_row_i,
  input  logic [CW-1:0]                    y_i,
  output logic [CW-1:0]                    y_o,
  input  logic [((N > 1) ? $clog2(N) : 1)-1:0] rd_idx_i,
  output logic [CW-1:0]                    rd_data_o
);
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic [CW-1:0]   prow_q [N];
  logic [CW-1:0]   brow_q [N];
  logic [CW-1:0]   yreg_q [N];
  logic [CW-1:0]   acc_q  [N];
  logic [CW-1:0]   prod_q;
  logic [IW-1:0]   pidx_q;
  logic            pfirst_q;
  logic            pv_q;
  logic [IW:0]     rsum;
  logic [IW:0]     rwrap;
  logic [IW-1:0]   ridx;
  logic [IW-1:0]   cidx;
  logic [CW-1:0]   x_op;
  logic [2*CW-1:0] full_prod;

  // row index of the base row currently at this cell
  always_comb begin
    rsum  = (IW+1)'(J) + (IW+1)'(ctrl_i.shift[IW-1:0]);
    rwrap = (rsum >= (IW+1)'(N)) ? rsum - (IW+1)'(N) : rsum;
    ridx  = rwrap[IW-1:0];
    cidx  = ctrl_i.col[IW-1:0];
    x_op  = ctrl_i.sel_b ? brow_q[ridx] : prow_q[ridx];
    full_prod = x_op * yreg_q[0];
  end

  assign y_o       = yreg_q[0];
  assign rd_data_o = prow_q[rd_idx_i];

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      prod_q   <= full_prod[CW-1:0];
      pidx_q   <= cidx;
      pfirst_q <= ctrl_i.first;
    end
  end

  // accumulate stage
  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      acc_q[pidx_q] <= pfirst_q ? prod_q : acc_q[pidx_q] + prod_q;
    end
  end

  // rotating base row, one element handed to the neighbor per beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_y) begin
      for (int k = 0; k < N; k++) begin
        yreg_q[k] <= brow_q[k];
      end
    end else if (ctrl_i.step) begin
      for (int k = 0; k < N - 1; k++) begin
        yreg_q[k] <= yreg_q[k+1];
      end
      yreg_q[N-1] <= y_i;
    end
  end

  // row storage: identity and adjacency on init, product on commit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      for (int k = 0; k < N; k++) begin
        prow_q[k] <= CW'(k == J);
        brow_q[k] <= CW'(adj_row_i[k]);
      end
    end else begin
      if (ctrl_i.commit_p) begin
        for (int k = 0; k < N; k++) begin
          prow_q[k] <= acc_q[k];
        end
      end
      if (ctrl_i.commit_b) begin
        for (int k = 0; k < N; k++) begin
          brow_q[k] <= acc_q[k];
        end
      end
    end
  end

endmodule
